// ----- rtl/core/stt_pkg.sv -----
// Shared types, constants and character helpers for the source text tokenizer.
`default_nettype none

package stt_pkg;

	// token length counter width, enough for the largest supported token size
	localparam int LEN_W       = 6;
	localparam int KW_COUNT    = 10;
	localparam int QUEUE_DEPTH = 4;

	// token classes
	localparam logic [2:0] CLS_KEYWORD   = 3'd0;
	localparam logic [2:0] CLS_IDENT     = 3'd1;
	localparam logic [2:0] CLS_NUMBER    = 3'd2;
	localparam logic [2:0] CLS_OPERATOR  = 3'd3;
	localparam logic [2:0] CLS_SEPARATOR = 3'd4;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_text;
	} src_item_t;

	typedef struct packed {
		logic [2:0] token_class;
		logic [7:0] token_char;
		logic [3:0] keyword_number;
		logic       last_of_token;
		logic       truncated;
	} tok_item_t;

	typedef enum logic [0:0] {
		CMD_CHAR  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_kind_t;

	// one unit of work from the front to the back
	typedef struct packed {
		cmd_kind_t        kind;
		logic [2:0]       cls;
		logic [7:0]       ch;
		logic [3:0]       kw;
		logic [LEN_W-1:0] len;
		logic             trunc;
		logic             bank;
	} cmd_t;

	// token buffer write port
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [LEN_W-1:0] idx;
		logic [7:0]       data;
	} buf_wr_t;

	// back has read the last character of a bank
	typedef struct packed {
		logic en;
		logic bank;
	} buf_rel_t;

	function automatic logic [2:0] kw_len(input logic [3:0] k);
		logic [2:0] n;
		unique case (k)
			4'd0: n = 3'd3;
			4'd1: n = 3'd4;
			4'd2: n = 3'd7;
			4'd3: n = 3'd5;
			4'd4: n = 3'd2;
			4'd5: n = 3'd4;
			4'd6: n = 3'd3;
			4'd7: n = 3'd5;
			4'd8: n = 3'd6;
			4'd9: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// character at position pos of keyword k
	function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
		logic [55:0] w;
		logic [55:0] sh;
		unique case (k)
			4'd0: w = {"int", 32'd0};
			4'd1: w = {"main", 24'd0};
			4'd2: w = "include";
			4'd3: w = {"float", 16'd0};
			4'd4: w = {"if", 40'd0};
			4'd5: w = {"else", 24'd0};
			4'd6: w = {"for", 32'd0};
			4'd7: w = {"while", 16'd0};
			4'd8: w = {"return", 8'd0};
			4'd9: w = {"char", 24'd0};
			default: w = '0;
		endcase
		sh = w << {pos, 3'b000};
		return sh[55:48];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == CH_TAB || c == CH_NEWLINE;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
			c == "<" || c == ">" || c == "!" || c == "&" || c == "|";
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return c == "(" || c == ")" || c == "{" || c == "}" ||
			c == "[" || c == "]" || c == "," || c == ";";
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/source_text_tokenizer.sv -----
// Source text tokenizer: top level joining scanner front, command queue and emitter back.
`default_nettype none

// Takes one source byte per transfer and returns tokens as runs of transfers, one
// character each, with class, keyword index, last-of-run and truncation flags. A
// character that ends a token or follows a lone slash is held while the front hands
// off the finished token or the slash, then rescanned from idle. Finished tokens
// wait in a two-bank token buffer and go out of the back at one character per cycle
// while the output is not stalled, read from the buffer memory's single read port,
// while the front keeps scanning into the other bank. The front stalls its input
// when the four-entry command queue is full, while a held character is rescanned,
// or when a new token would start while both banks still hold runs not yet read
// out. A run's first character passes through the run register, the stage-one read
// register and the output register. MAX_TOKEN (8 to 63) sets the longest token
// kept; longer ones are cut to MAX_TOKEN characters and flagged truncated.
module source_text_tokenizer import stt_pkg::*; #(
	parameter int MAX_TOKEN = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok_data
);

	logic     q_push;
	cmd_t     q_cmd;
	logic     q_full;
	logic     q_pop;
	cmd_t     q_head;
	logic     q_empty;
	buf_wr_t  buf_wr;
	buf_rel_t buf_rel;

	stt_front #(
		.MAX_TOKEN(MAX_TOKEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.q_push   (q_push),
		.q_cmd    (q_cmd),
		.q_full   (q_full),
		.buf_wr   (buf_wr),
		.buf_rel  (buf_rel)
	);

	stt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (q_head),
		.empty   (q_empty)
	);

	stt_back #(
		.MAX_TOKEN(MAX_TOKEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_cmd    (q_head),
		.buf_wr   (buf_wr),
		.buf_rel  (buf_rel),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data (tok_data)
	);

	// front never pushes into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// front never writes the bank the back is releasing
	a_bank_owner: assert property (@(posedge clk) disable iff (!arst_n)
		buf_wr.en && buf_rel.en |-> buf_wr.bank != buf_rel.bank)
		else $error("token buffer bank written while being read out");

	// single-character tokens are complete runs with no flags
	a_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_data.token_class == CLS_OPERATOR ||
			tok_data.token_class == CLS_SEPARATOR)
		|-> tok_data.last_of_token && !tok_data.truncated &&
			tok_data.keyword_number == 4'd0)
		else $error("operator or separator transfer with run flags");

	// a truncated token is never a keyword
	a_kw_whole: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_data.token_class == CLS_KEYWORD |-> !tok_data.truncated)
		else $error("truncated token classed as keyword");

endmodule

`default_nettype wire

// ----- rtl/core/stt_front.sv -----
// Scanner front: takes characters, tracks comments and tokens, fills the token buffer.
`default_nettype none

module stt_front import stt_pkg::*; #(
	parameter int MAX_TOKEN = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      q_push,
	output cmd_t      q_cmd,
	input  logic      q_full,
	output buf_wr_t   buf_wr,
	input  buf_rel_t  buf_rel
);

	typedef enum logic [5:0] {
		M_IDLE  = 6'b000001,
		M_TOKEN = 6'b000010,
		M_SLASH = 6'b000100,
		M_LINE  = 6'b001000,
		M_BLOCK = 6'b010000,
		M_STAR  = 6'b100000
	} mode_t;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN);

	logic                hold_valid_q, hold_valid_d;
	src_item_t           hold_q;
	mode_t               mode_q, mode_d;
	logic                bank_q, bank_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic                num_q, num_d;
	logic                ovf_q, ovf_d;
	logic [KW_COUNT-1:0] kw_ok_q, kw_ok_d;
	logic [1:0]          busy_q, busy_d;

	logic       done;
	logic       flush;
	logic       idle_path;
	logic       cont;
	logic [7:0] ch;
	logic       kw_found;
	logic [3:0] kw_idx;
	logic       is_kw;
	cmd_t       flush_cmd;

	// keyword lookup from the running per-keyword match bits
	always_comb begin
		kw_found = 1'b0;
		kw_idx   = '0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (kw_ok_q[k] && len_q == LEN_W'(kw_len(4'(k)))) begin
				kw_found = 1'b1;
				kw_idx   = 4'(k);
			end
		end
		is_kw = kw_found && !num_q && !ovf_q;

		flush_cmd       = '0;
		flush_cmd.kind  = CMD_FLUSH;
		flush_cmd.cls   = num_q ? CLS_NUMBER : (is_kw ? CLS_KEYWORD : CLS_IDENT);
		flush_cmd.kw    = is_kw ? kw_idx : 4'd0;
		flush_cmd.len   = len_q;
		flush_cmd.trunc = ovf_q;
		flush_cmd.bank  = bank_q;
	end

	// scanner step on the held character
	always_comb begin
		ch        = hold_q.in_char;
		cont      = num_q ? (is_digit(ch) || ch == ".")
			: (is_letter(ch) || is_digit(ch) || ch == "_");
		done      = 1'b0;
		flush     = 1'b0;
		idle_path = 1'b0;
		q_push    = 1'b0;
		q_cmd     = '0;
		buf_wr    = '0;
		mode_d    = mode_q;
		bank_d    = bank_q;
		len_d     = len_q;
		num_d     = num_q;
		ovf_d     = ovf_q;
		kw_ok_d   = kw_ok_q;

		if (hold_valid_q) begin
			if (hold_q.end_of_text) begin
				if (mode_q == M_TOKEN) begin
					if (!q_full) begin
						flush = 1'b1;
						done  = 1'b1;
					end
				end else if (mode_q == M_SLASH) begin
					if (!q_full) begin
						q_push    = 1'b1;
						q_cmd.cls = CLS_OPERATOR;
						q_cmd.ch  = "/";
						done      = 1'b1;
					end
				end else begin
					done = 1'b1;
				end
				if (done) begin
					mode_d = M_IDLE;
				end
			end else begin
				unique case (mode_q)
					M_IDLE: begin
						idle_path = 1'b1;
					end
					M_TOKEN: begin
						if (cont) begin
							done = 1'b1;
							if (len_q < MAX_LEN) begin
								buf_wr.en   = 1'b1;
								buf_wr.bank = bank_q;
								buf_wr.idx  = len_q;
								buf_wr.data = ch;
								len_d       = len_q + LEN_W'(1);
								for (int k = 0; k < KW_COUNT; k++) begin
									kw_ok_d[k] = kw_ok_q[k] &&
										(len_q < LEN_W'(kw_len(4'(k)))) &&
										(kw_char(4'(k), len_q[2:0]) == ch);
								end
							end else begin
								ovf_d = 1'b1;
							end
						end else if (!q_full) begin
							// token ends; the character is rescanned from idle next cycle
							flush  = 1'b1;
							mode_d = M_IDLE;
						end
					end
					M_SLASH: begin
						if (ch == "/") begin
							mode_d = M_LINE;
							done   = 1'b1;
						end else if (ch == "*") begin
							mode_d = M_BLOCK;
							done   = 1'b1;
						end else if (!q_full) begin
							// lone slash goes out, character rescanned from idle
							q_push    = 1'b1;
							q_cmd.cls = CLS_OPERATOR;
							q_cmd.ch  = "/";
							mode_d    = M_IDLE;
						end
					end
					M_LINE: begin
						done = 1'b1;
						if (ch == CH_NEWLINE) begin
							mode_d = M_IDLE;
						end
					end
					M_BLOCK: begin
						done = 1'b1;
						if (ch == "*") begin
							mode_d = M_STAR;
						end
					end
					M_STAR: begin
						done = 1'b1;
						if (ch == "/") begin
							mode_d = M_IDLE;
						end else if (ch != "*") begin
							mode_d = M_BLOCK;
						end
					end
					default: begin
						mode_d = M_IDLE;
					end
				endcase

				if (idle_path) begin
					if (is_blank(ch)) begin
						done = 1'b1;
					end else if (ch == "/") begin
						mode_d = M_SLASH;
						done   = 1'b1;
					end else if (is_letter(ch) || ch == "_" || is_digit(ch)) begin
						// start a token once the current bank has drained
						if (!busy_q[bank_q]) begin
							buf_wr.en   = 1'b1;
							buf_wr.bank = bank_q;
							buf_wr.idx  = '0;
							buf_wr.data = ch;
							len_d       = LEN_W'(1);
							num_d       = is_digit(ch);
							ovf_d       = 1'b0;
							for (int k = 0; k < KW_COUNT; k++) begin
								kw_ok_d[k] = kw_char(4'(k), 3'd0) == ch;
							end
							mode_d = M_TOKEN;
							done   = 1'b1;
						end
					end else if (is_op(ch) || is_sep(ch)) begin
						if (!q_full) begin
							q_push    = 1'b1;
							q_cmd.cls = is_op(ch) ? CLS_OPERATOR : CLS_SEPARATOR;
							q_cmd.ch  = ch;
							done      = 1'b1;
						end
					end else begin
						done = 1'b1;
					end
				end
			end
		end

		if (flush) begin
			q_push = 1'b1;
			q_cmd  = flush_cmd;
			bank_d = ~bank_q;
			len_d  = '0;
			num_d  = 1'b0;
			ovf_d  = 1'b0;
		end
	end

	// bank ownership: set on flush, cleared when the back has read the run
	always_comb begin
		busy_d = busy_q;
		if (buf_rel.en) begin
			busy_d[buf_rel.bank] = 1'b0;
		end
		if (flush) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	assign src_stall    = hold_valid_q && !done;
	assign hold_valid_d = (src_valid && !src_stall) ? 1'b1 : (done ? 1'b0 : hold_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			mode_q       <= M_IDLE;
			bank_q       <= 1'b0;
			len_q        <= '0;
			num_q        <= 1'b0;
			ovf_q        <= 1'b0;
			kw_ok_q      <= '0;
			busy_q       <= '0;
		end else begin
			hold_valid_q <= hold_valid_d;
			mode_q       <= mode_d;
			bank_q       <= bank_d;
			len_q        <= len_d;
			num_q        <= num_d;
			ovf_q        <= ovf_d;
			kw_ok_q      <= kw_ok_d;
			busy_q       <= busy_d;
		end
	end

	// input holding register
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			hold_q <= src_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stt_queue.sv -----
// Small command queue between the scanner front and the emitter back.
`default_nettype none

module stt_queue import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stt_back.sv -----
// Emitter back: token buffer memory, token run readout and output register.
`default_nettype none

module stt_back import stt_pkg::*; #(
	parameter int MAX_TOKEN = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	output logic      q_pop,
	input  cmd_t      q_cmd,
	input  buf_wr_t   buf_wr,
	output buf_rel_t  buf_rel,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_item_t tok_data
);

	localparam int IW    = $clog2(MAX_TOKEN);
	localparam int DEPTH = 2 ** (IW + 1);

	logic [7:0] mem [DEPTH];

	cmd_t             run_q;
	logic             run_active_q;
	logic [LEN_W-1:0] idx_q;

	logic       valid_s1;
	tok_item_t  item_s1;
	logic       from_mem_s1;
	logic [7:0] rdata_s1;

	logic      out_valid_q;
	tok_item_t out_q;

	logic      s1_move;
	logic      s1_free;
	logic      run_last;
	logic      rd_en;
	logic      load_char;
	tok_item_t s1_item;

	// stage control
	always_comb begin
		s1_move   = valid_s1 && (!out_valid_q || !tok_stall);
		s1_free   = !valid_s1 || s1_move;
		run_last  = idx_q == (run_q.len - LEN_W'(1));
		rd_en     = s1_free && run_active_q;
		q_pop     = s1_free && !run_active_q && !q_empty;
		load_char = q_pop && (q_cmd.kind == CMD_CHAR);

		buf_rel.en   = rd_en && run_last;
		buf_rel.bank = run_q.bank;

		s1_item = item_s1;
		if (from_mem_s1) begin
			s1_item.token_char = rdata_s1;
		end
	end

	// token buffer, two banks
	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[{buf_wr.bank, buf_wr.idx[IW-1:0]}] <= buf_wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[{run_q.bank, idx_q[IW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q <= 1'b0;
			idx_q        <= '0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				idx_q <= idx_q + LEN_W'(1);
				if (run_last) begin
					run_active_q <= 1'b0;
				end
			end else if (q_pop && q_cmd.kind == CMD_FLUSH) begin
				run_active_q <= 1'b1;
				idx_q        <= '0;
			end

			if (rd_en || load_char) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!tok_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_FLUSH) begin
			run_q <= q_cmd;
		end
		if (rd_en) begin
			item_s1.token_class    <= run_q.cls;
			item_s1.token_char     <= 8'd0;
			item_s1.keyword_number <= run_q.kw;
			item_s1.last_of_token  <= run_last;
			item_s1.truncated      <= run_q.trunc;
			from_mem_s1            <= 1'b1;
		end else if (load_char) begin
			item_s1.token_class    <= q_cmd.cls;
			item_s1.token_char     <= q_cmd.ch;
			item_s1.keyword_number <= 4'd0;
			item_s1.last_of_token  <= 1'b1;
			item_s1.truncated      <= 1'b0;
			from_mem_s1            <= 1'b0;
		end
		if (s1_move) begin
			out_q <= s1_item;
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_data  = out_q;

endmodule

`default_nettype wire
